// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/stsid_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted table package
// Shared constants, request and status codes, and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stsid_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int KEY_W        = 32;
    localparam int ACTION_W     = 2;
    localparam int COUNT_OUT_W  = 7;
    localparam int OUT_DATA_W   = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SEARCH = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic                   found;
        status_t                status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } result_t;

endpackage

// ----- rtl/sorted_table_insert_search_delete_unit.sv -----
// ----------------------------------------------------------------------------
// Sorted table insert/search/delete unit
// Ascending key table in one RAM with search, insert and delete requests.
//
//  channel   dir  tdata                       tuser
//  s_axis    in   [31:0] key                  [1:0] action
//  m_axis    out  [0] found, [2:1] status,    -
//                 [9:3] entry_count
//
// Every entry scanned or moved costs one read and one compare or write on the
// single-read-port key RAM, whose read data is registered.
// Reset clears the entry count and the control state but not the RAM; the RAM needs no clearing pass.
// The result waits in an output register while the next item is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_table_insert_search_delete_unit #(
    parameter int CAPACITY = stsid_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = stsid_pkg::KEY_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [stsid_pkg::KEY_W-1:0]      s_axis_tdata,   // key
    input  logic [stsid_pkg::ACTION_W-1:0]   s_axis_tuser,   // action
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [stsid_pkg::OUT_DATA_W-1:0] m_axis_tdata    // found, status, entry_count
);

    import stsid_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    result_t             res;
    logic                res_valid;
    logic                res_ready;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [KEY_BITS-1:0] mem_wr_data;
    logic [AW-1:0]       mem_rd_addr;
    logic [KEY_BITS-1:0] mem_rd_data;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg,  out_data_next;

    stsid_seq #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req_action  (action_t'(s_axis_tuser)),
        .req_key     (s_axis_tdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    stsid_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_keys (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign res_ready     = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = {(OUT_DATA_W - COUNT_OUT_W - 3)'(0),
                                 res.entry_count, res.status, res.found};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ----- rtl/stsid_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stsid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/stsid_seq.sv -----
// ----------------------------------------------------------------------------
// Sorted table sequencer
// Scans, shifts and writes the key memory one entry at a time per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stsid_seq #(
    parameter int CAPACITY = stsid_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = stsid_pkg::KEY_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  stsid_pkg::action_t          req_action,
    input  logic [stsid_pkg::KEY_W-1:0] req_key,
    output logic                        res_valid,
    input  logic                        res_ready,
    output stsid_pkg::result_t          res,
    output logic                        mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
    output logic [KEY_BITS-1:0]         mem_wr_data,
    output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
    input  logic [KEY_BITS-1:0]         mem_rd_data
);

    import stsid_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHL_RD,
        S_SHL_WR,
        S_INS_RD,
        S_INS_WR,
        S_DONE
    } state_t;

    state_t             state_reg,  state_next;
    action_t            act_reg,    act_next;
    logic [KEY_BITS-1:0] key_reg,   key_next;
    logic [CW-1:0]      idx_reg,    idx_next;
    logic [CW-1:0]      count_reg,  count_next;
    logic               found_reg,  found_next;
    status_t            status_reg, status_next;

    logic [63:0]         key_ext;
    logic [KEY_BITS-1:0] key_in;
    logic [CW:0]         idx_p1;
    logic [CW:0]         idx_p2;
    logic [CW:0]         cnt_w;
    logic [CW-1:0]       idx_m1;
    logic [31:0]         cnt_ext;
    logic                is_full;
    logic                is_empty;

    assign key_ext  = 64'(req_key);
    assign key_in   = key_ext[KEY_BITS-1:0];
    assign idx_p1   = {1'b0, idx_reg} + (CW + 1)'(1);
    assign idx_p2   = {1'b0, idx_reg} + (CW + 1)'(2);
    assign cnt_w    = {1'b0, count_reg};
    assign idx_m1   = idx_reg - CW'(1);
    assign cnt_ext  = 32'(count_reg);
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign req_ready       = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_DONE);
    assign res.found       = found_reg;
    assign res.status      = status_reg;
    assign res.entry_count = cnt_ext[COUNT_OUT_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        status_next = status_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg[AW-1:0];
        mem_wr_data = key_reg;
        mem_rd_addr = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next    = req_action;
                    key_next    = key_in;
                    found_next  = 1'b0;
                    status_next = STAT_OK;
                    idx_next    = '0;
                    case (req_action)
                        ACT_SEARCH:
                        begin
                            state_next = is_empty ? S_DONE : S_SCAN_RD;
                        end
                        ACT_INSERT:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (mem_rd_data >= key_reg)
                begin
                    if (mem_rd_data == key_reg)
                    begin
                        found_next = 1'b1;
                        if (act_reg == ACT_DELETE && idx_p1 < cnt_w)
                        begin
                            state_next = S_SHL_RD;
                        end
                        else
                        begin
                            if (act_reg == ACT_DELETE)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        if (act_reg == ACT_DELETE)
                        begin
                            status_next = STAT_NOT_FOUND;
                        end
                        state_next = S_DONE;
                    end
                end
                else if (idx_p1 == cnt_w)
                begin
                    if (act_reg == ACT_DELETE)
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_p1[CW-1:0];
                    state_next = S_SCAN_RD;
                end
            end
            S_SHL_RD:
            begin
                mem_rd_addr = idx_p1[AW-1:0];
                state_next  = S_SHL_WR;
            end
            S_SHL_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data;
                idx_next    = idx_p1[CW-1:0];
                if (idx_p2 < cnt_w)
                begin
                    state_next = S_SHL_RD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_wr_en  = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    mem_rd_addr = idx_m1[AW-1:0];
                    state_next  = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                mem_wr_en = 1'b1;
                if (mem_rd_data >= key_reg)
                begin
                    mem_wr_data = mem_rd_data;
                    idx_next    = idx_m1;
                    state_next  = S_INS_RD;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            act_reg    <= ACT_SEARCH;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            status_reg <= STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            act_reg    <= act_next;
            idx_reg    <= idx_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(CAPACITY), "count above capacity")
    `ASSERT_IMPLIES(a_wr_state, clk, rst_n, mem_wr_en, state_reg == S_INS_RD || state_reg == S_INS_WR || state_reg == S_SHL_WR, "write outside shift")
    `ASSERT_NEXT(a_accept_leaves, clk, rst_n, req_valid && req_ready, state_reg != S_IDLE, "accepted item left idle")

endmodule

// ----- sim/sorted_table_insert_search_delete_unit_test.sv -----
// ----------------------------------------------------------------------------
// Sorted table insert/search/delete unit testbench
// Streams search, insert, delete and unused-code requests into the unit and
// checks every result against an in-bench sorted table. The stimulus begins
// with a directed list and then runs fill, drain and mixed rounds with random
// keys. Both sides of the stream stall in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_table_insert_search_delete_unit_test;

    import stsid_pkg::*;

    localparam int          CAPACITY     = CAPACITY_DEF;
    localparam int          RANDOM_ITEMS = 700;
    localparam int          QUIET_TAIL   = 100;
    localparam int          LIMIT_CYCLES = 1500000;
    localparam logic [1:0]  ACT_NOP      = 2'd3;

    typedef struct {
        logic [ACTION_W-1:0] op;
        logic [KEY_W-1:0]    key;
        bit                  hold;
    } request_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [KEY_W-1:0]      s_axis_tdata  = '0;
    logic [ACTION_W-1:0]   s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    request_t          pending_requests[$];
    result_t           result_due[$];
    logic [KEY_W-1:0]  held_keys[$];
    logic [KEY_W-1:0]  key_shadow[$];

    int errors      = 0;
    int cycle_count = 0;
    int send_gap    = 0;
    int recv_gap    = 0;
    int peak_fill   = 0;
    int hits        = 0;
    int op_seen[4]     = '{0, 0, 0, 0};
    int status_seen[4] = '{0, 0, 0, 0};

    sorted_table_insert_search_delete_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    function automatic result_t apply_request(logic [ACTION_W-1:0] op, logic [KEY_W-1:0] k);
        result_t r;
        int      pos;
        bit      hit;
        r.found  = 1'b0;
        r.status = STAT_OK;
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < k)
            pos++;
        hit = (pos < held_keys.size()) && (held_keys[pos] == k);
        case (op)
            ACT_SEARCH:
                r.found = hit;
            ACT_INSERT:
                if (held_keys.size() >= CAPACITY)
                    r.status = STAT_FULL;
                else
                    held_keys.insert(pos, k);
            ACT_DELETE:
                if (held_keys.size() == 0)
                    r.status = STAT_EMPTY;
                else if (hit)
                begin
                    held_keys.delete(pos);
                    r.found = 1'b1;
                end
                else
                    r.status = STAT_NOT_FOUND;
            default:
                r.found = 1'b0;
        endcase
        r.entry_count = COUNT_OUT_W'(held_keys.size());
        op_seen[op]++;
        status_seen[r.status]++;
        if (r.found)
            hits++;
        if (held_keys.size() > peak_fill)
            peak_fill = held_keys.size();
        return r;
    endfunction

    function automatic bit quiet_phase();
        return pending_requests.size() < QUIET_TAIL;
    endfunction

    task automatic report(input string msg);
        $display("mismatch @%0d: %s", cycle_count, msg);
        errors++;
    endtask

    task automatic queue_request(input logic [ACTION_W-1:0] op, input logic [KEY_W-1:0] k,
                                 input bit hold);
        request_t req;
        int       idx;
        req.op   = op;
        req.key  = k;
        req.hold = hold;
        pending_requests.push_back(req);
        if (op == ACT_INSERT && key_shadow.size() < CAPACITY)
            key_shadow.push_back(k);
        else if (op == ACT_DELETE)
        begin
            idx = -1;
            foreach (key_shadow[j])
                if (idx < 0 && key_shadow[j] == k)
                    idx = j;
            if (idx >= 0)
                key_shadow.delete(idx);
        end
    endtask

    function automatic logic [KEY_W-1:0] fresh_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return KEY_W'($urandom_range(0, 15));
            5:             return 32'hFFFF_FFFF - $urandom_range(0, 3);
            6:             return 32'h7FFF_FFFE + $urandom_range(0, 3);
            default:       return $urandom;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] stored_or_fresh(input int pct);
        if (key_shadow.size() != 0 && $urandom_range(0, 99) < pct)
            return key_shadow[$urandom_range(0, key_shadow.size() - 1)];
        return fresh_key();
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                result_due.push_back(apply_request(pending_requests[0].op,
                                                   pending_requests[0].key));
                pending_requests.delete(0);
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_requests.size() == 0 ||
                         (pending_requests[0].hold && result_due.size() != 0))
                    s_axis_tvalid <= 1'b0;
                else if (!quiet_phase() && $urandom_range(0, 11) == 0)
                begin
                    send_gap = $urandom_range(0, 17);
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_requests[0].key;
                    s_axis_tuser  <= pending_requests[0].op;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        logic                   got_found;
        logic [1:0]             got_status;
        logic [COUNT_OUT_W-1:0] got_count;
        result_t                want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_found  = m_axis_tdata[0];
                got_status = m_axis_tdata[2:1];
                got_count  = m_axis_tdata[9:3];
                if (result_due.size() == 0)
                    report("result with no request outstanding");
                else
                begin
                    want = result_due.pop_front();
                    if (got_found !== want.found)
                        report($sformatf("found %b, want %b", got_found, want.found));
                    if (got_status !== want.status)
                        report($sformatf("status %0d, want %s", got_status,
                                         want.status.name()));
                    if (got_count !== want.entry_count)
                        report($sformatf("entry_count %0d, want %0d", got_count,
                                         want.entry_count));
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet_phase() && $urandom_range(0, 11) == 0)
            begin
                recv_gap = $urandom_range(0, 17);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int made;
        int round;
        int len;
        int roll;
        logic [ACTION_W-1:0] op;
        logic [KEY_W-1:0]    k;

        queue_request(ACT_SEARCH, 32'h0000_0000, 1'b0);
        queue_request(ACT_DELETE, 32'h0000_0005, 1'b0);
        queue_request(ACT_NOP,    32'h0000_0000, 1'b0);
        queue_request(ACT_INSERT, 32'hFFFF_FFFF, 1'b0);
        queue_request(ACT_INSERT, 32'h0000_0000, 1'b0);
        queue_request(ACT_INSERT, 32'h0000_0000, 1'b0);
        queue_request(ACT_INSERT, 32'hAAAA_AAAA, 1'b0);
        queue_request(ACT_INSERT, 32'h5555_5555, 1'b0);
        queue_request(ACT_SEARCH, 32'h0000_0000, 1'b0);
        queue_request(ACT_SEARCH, 32'hFFFF_FFFF, 1'b0);
        queue_request(ACT_SEARCH, 32'h0000_0007, 1'b0);
        queue_request(ACT_DELETE, 32'h0000_0007, 1'b0);
        queue_request(ACT_DELETE, 32'h0000_0000, 1'b0);
        queue_request(ACT_SEARCH, 32'h0000_0000, 1'b0);
        queue_request(ACT_DELETE, 32'h0000_0000, 1'b0);
        queue_request(ACT_SEARCH, 32'h0000_0000, 1'b0);
        queue_request(ACT_NOP,    32'hFFFF_FFFF, 1'b1);
        queue_request(ACT_DELETE, 32'hFFFF_FFFF, 1'b0);
        queue_request(ACT_DELETE, 32'hAAAA_AAAA, 1'b0);
        queue_request(ACT_DELETE, 32'h5555_5555, 1'b0);
        queue_request(ACT_DELETE, 32'h0000_0000, 1'b0);

        // fill, drain and mixed rounds
        made  = 0;
        round = 0;
        while (made < RANDOM_ITEMS)
        begin
            len = (round % 3 == 2) ? 60 : 110;
            for (int i = 0; i < len && made < RANDOM_ITEMS; i++)
            begin
                roll = $urandom_range(0, 99);
                case (round % 3)
                    0:       op = roll < 78 ? ACT_INSERT : roll < 88 ? ACT_SEARCH :
                                  roll < 97 ? ACT_DELETE : ACT_NOP;
                    1:       op = roll < 10 ? ACT_INSERT : roll < 20 ? ACT_SEARCH :
                                  roll < 97 ? ACT_DELETE : ACT_NOP;
                    default: op = roll < 30 ? ACT_INSERT : roll < 60 ? ACT_SEARCH :
                                  roll < 95 ? ACT_DELETE : ACT_NOP;
                endcase
                if (op == ACT_INSERT)
                    k = stored_or_fresh(30);
                else if (op == ACT_NOP)
                    k = fresh_key();
                else
                    k = stored_or_fresh(80);
                queue_request(op, k, made % 150 == 75);
                made++;
            end
            round++;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || result_due.size() != 0)
            @(posedge clk);
        repeat (2 * CAPACITY + 20) @(posedge clk);

        $display("requests: %0d search, %0d insert, %0d delete, %0d unused code",
                 op_seen[ACT_SEARCH], op_seen[ACT_INSERT], op_seen[ACT_DELETE],
                 op_seen[ACT_NOP]);
        $display("outcomes: %0d hits, %0d not found, %0d empty, %0d full, peak fill %0d",
                 hits, status_seen[STAT_NOT_FOUND], status_seen[STAT_EMPTY],
                 status_seen[STAT_FULL], peak_fill);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
